[hw/rtl/lsu_pkg.sv]
// Package for the load/store unit: request codes, payload structs, FSM states
// and controller/datapath command and status types. No dependencies.
`default_nettype none
package lsu_pkg;
	localparam int MemBytesDefault = 4096;

	typedef enum logic [2:0] {
		REQ_REG_WR = 3'd0, REQ_REG_RD = 3'd1, REQ_LOAD = 3'd2, REQ_STORE = 3'd3,
		REQ_LMW = 3'd4, REQ_STMW = 3'd5, REQ_LSW = 3'd6, REQ_STSW = 3'd7
	} req_type_t;

	localparam int FlUpdate = 0;
	localparam int FlIndexed = 1;
	localparam int FlSext = 2;
	localparam int FlRev = 3;
	localparam int FlRsv = 4;
	localparam int FlZero = 5;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [1:0]         access_size;
		logic [5:0]         mode_flags;
		logic [4:0]         reg_a;
		logic [4:0]         reg_b;
		logic [4:0]         reg_d;
		logic signed [15:0] displacement;
		logic [4:0]         string_count;
		logic [6:0]         xer_count;
		logic               summary_overflow;
		logic [31:0]        write_value;
	} lsu_in_t;

	typedef struct packed {
		logic [31:0] data_value;
		logic [31:0] effective_address;
		logic [3:0]  cr_field;
		logic        store_performed;
	} lsu_out_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ADDR, ST_BYTE, ST_FINISH, ST_DONE
	} lsu_state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture item
		logic calc_ea;   // compute EA, set up byte walk
		logic step;      // one byte of memory traffic
		logic finish;    // register writeback, reservation
		logic emit;      // drive the result
	} lsu_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_mem;    // item needs address/byte phases
		logic last_byte; // current byte is the last one
		logic no_bytes;  // nothing to move
	} lsu_sts_t;
endpackage
`default_nettype wire

[hw/rtl/lsu_ctrl.sv]
// Controller state machine of the load/store unit.
// Depends on lsu_pkg.
`default_nettype none
module lsu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output lsu_pkg::lsu_cmd_t      cmd,
	input  wire lsu_pkg::lsu_sts_t sts
);
	import lsu_pkg::*;

	lsu_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: begin
				cmd.calc_ea = 1'b1;
				state_d = sts.is_mem ? ST_BYTE : ST_FINISH;
			end
			ST_BYTE: begin
				if (sts.no_bytes) state_d = ST_FINISH;
				else begin
					cmd.step = 1'b1;
					if (sts.last_byte) state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit) else $error("double emit");
	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == ST_ADDR) else $error("latch not followed by address");
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> busy) else $error("step while idle");
endmodule
`default_nettype wire

[hw/rtl/lsu_dp.sv]
// Datapath of the load/store unit: register file, reservation, byte memory,
// EA adder and a byte walker for all memory forms. Depends on lsu_pkg.
`default_nettype none
module lsu_dp #(
	parameter int MEM_BYTES = lsu_pkg::MemBytesDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsu_pkg::lsu_in_t  in_item,
	input  wire lsu_pkg::lsu_cmd_t cmd,
	output lsu_pkg::lsu_sts_t      sts,
	output lsu_pkg::lsu_out_t      res,
	output logic                   res_valid
);
	import lsu_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	lsu_in_t     it_q;
	logic [31:0] gpr_q [32];
	logic        rsv_valid_q;
	logic [31:0] rsv_addr_q;
	logic [7:0]  mem [MEM_BYTES];

	logic [31:0] ea_q, addr_q, acc_q, dv_q;
	logic [7:0]  cnt_q;       // bytes left
	logic [2:0]  nb_q;
	logic [1:0]  bidx_q;      // byte index within word (multiple/string) or item
	logic [4:0]  reg_q;       // current register for multiple/string
	logic        doit_q;
	logic [3:0]  cr_q;
	logic [7:0]  rd_byte;     // memory read data, registered

	req_type_t rt;
	assign rt = req_type_t'(it_q.req_type);

	logic is_single, is_multi, is_str, is_loadish;
	assign is_single = (rt == REQ_LOAD) || (rt == REQ_STORE);
	assign is_multi = (rt == REQ_LMW) || (rt == REQ_STMW);
	assign is_str = (rt == REQ_LSW) || (rt == REQ_STSW);
	assign is_loadish = (rt == REQ_LOAD) || (rt == REQ_LMW) || (rt == REQ_LSW);

	assign sts.is_mem = is_single || is_multi || is_str;
	assign sts.last_byte = (cnt_q == 8'd1);
	assign sts.no_bytes = (cnt_q == 8'd0);

	// EA calculation, byte count and conditional-store outcome
	logic [31:0] base, offs, ea_c, disp_x;
	logic [2:0]  nb_c;
	logic [7:0]  n_c;
	logic        doit_c;
	logic [3:0]  cr_c;
	always_comb begin
		disp_x = {{16{it_q.displacement[15]}}, it_q.displacement};
		unique case (it_q.access_size)
			2'd0: nb_c = 3'd1;
			2'd1: nb_c = 3'd2;
			default: nb_c = 3'd4;
		endcase
		if (is_single)
			base = (it_q.mode_flags[FlZero] && it_q.reg_a == 5'd0) ? 32'd0 : gpr_q[it_q.reg_a];
		else
			base = (it_q.reg_a == 5'd0) ? 32'd0 : gpr_q[it_q.reg_a];
		if (is_multi) offs = disp_x;
		else if (is_str) offs = it_q.mode_flags[FlIndexed] ? gpr_q[it_q.reg_b] : 32'd0;
		else offs = it_q.mode_flags[FlIndexed] ? gpr_q[it_q.reg_b] : disp_x;
		ea_c = base + offs;
		doit_c = 1'b1;
		cr_c = '0;
		if (rt == REQ_STORE && it_q.mode_flags[FlRsv]) begin
			cr_c = {2'b00, rsv_valid_q, it_q.summary_overflow};
			doit_c = rsv_valid_q;
		end
		if (is_single) n_c = doit_c ? {5'd0, nb_c} : 8'd0;
		else if (is_multi) n_c = {(6'd32 - {1'b0, it_q.reg_d}), 2'b00};
		else if (it_q.mode_flags[FlIndexed]) n_c = {1'b0, it_q.xer_count};
		else n_c = (it_q.string_count == 5'd0) ? 8'd32 : {3'd0, it_q.string_count};
	end

	// byte being stored at the current position
	logic [31:0] src_w;
	logic [4:0]  sh;
	logic [7:0]  st_byte;
	logic [AW-1:0] maddr;
	always_comb begin
		src_w = is_single ? gpr_q[it_q.reg_d] : gpr_q[reg_q];
		if (is_single && it_q.mode_flags[FlRev]) sh = {bidx_q, 3'b000};
		else if (is_single) sh = {(nb_q[1:0] - 2'd1 - bidx_q), 3'b000};
		else sh = {~bidx_q, 3'b000};
		st_byte = 8'(src_w >> sh);
		maddr = addr_q[AW-1:0];
	end

	// read happens combinationally-addressed, registered data; the resulting skew
	// is handled by collecting the previous read on the next step or at finish.
	logic       pend_q;      // rd_byte holds a byte still to be merged
	logic [1:0] pidx_q;
	logic [4:0] preg_q;

	always_ff @(posedge clk) begin
		if (cmd.step && !is_loadish) mem[maddr] <= st_byte;
		rd_byte <= mem[maddr];
	end

	// merge a read byte into the single-load accumulator
	function automatic logic [31:0] merge_single(input logic [31:0] acc,
		input logic [7:0] b, input logic [1:0] k, input logic rev);
		logic [31:0] r;
		if (rev) r = acc | ({24'd0, b} << {k, 3'b000});
		else r = {acc[23:0], b};
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 32; i++) gpr_q[i] <= '0;
			rsv_valid_q <= 1'b0;
			rsv_addr_q <= '0;
			res_valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			res_valid <= cmd.emit;
			if (cmd.latch) it_q <= in_item;
			if (cmd.calc_ea) begin
				ea_q <= sts.is_mem ? ea_c : 32'd0;
				addr_q <= ea_c;
				cnt_q <= n_c;
				nb_q <= nb_c;
				bidx_q <= 2'd0;
				reg_q <= it_q.reg_d;
				doit_q <= doit_c;
				cr_q <= cr_c;
				acc_q <= '0;
				pend_q <= 1'b0;
				if (rt == REQ_STORE && it_q.mode_flags[FlRsv]) rsv_valid_q <= 1'b0;
				if (rt == REQ_REG_WR) gpr_q[it_q.reg_d] <= it_q.write_value;
				if (rt == REQ_REG_RD) dv_q <= gpr_q[it_q.reg_d];
				else dv_q <= '0;
			end
			// commit a pending read byte
			if (pend_q && (cmd.step || cmd.finish)) begin
				if (rt == REQ_LOAD) begin
					acc_q <= merge_single(acc_q, rd_byte, pidx_q, it_q.mode_flags[FlRev]);
				end else if (rt == REQ_LMW) begin
					gpr_q[preg_q] <= (pidx_q == 2'd0) ? {rd_byte, 24'd0}
						: gpr_q[preg_q] | ({24'd0, rd_byte} << {~pidx_q, 3'b000});
				end else if (rt == REQ_LSW) begin
					gpr_q[preg_q] <= (pidx_q == 2'd0) ? {rd_byte, 24'd0}
						: gpr_q[preg_q] | ({24'd0, rd_byte} << {~pidx_q, 3'b000});
				end
			end
			if (cmd.step) begin
				pend_q <= is_loadish;
				pidx_q <= bidx_q;
				preg_q <= reg_q;
				addr_q <= addr_q + 32'd1;
				cnt_q <= cnt_q - 8'd1;
				bidx_q <= bidx_q + 2'd1;
				if (!is_single && bidx_q == 2'd3) reg_q <= reg_q + 5'd1;
			end
			if (cmd.finish) begin
				pend_q <= 1'b0;
			end
			if (cmd.emit) begin
				res.effective_address <= ea_q;
				res.cr_field <= cr_q;
				if (rt == REQ_LOAD) begin
					logic [31:0] v;
					v = acc_q;
					if (it_q.mode_flags[FlSext]) begin
						if (nb_q == 3'd1 && v[7]) v = v | 32'hFFFFFF00;
						else if (nb_q == 3'd2 && v[15]) v = v | 32'hFFFF0000;
					end
					res.data_value <= v;
					res.store_performed <= 1'b0;
					// base update wins over the target when both name one register
					if (!(it_q.mode_flags[FlUpdate] && it_q.reg_a == it_q.reg_d))
						gpr_q[it_q.reg_d] <= v;
					if (it_q.mode_flags[FlRsv]) begin
						rsv_valid_q <= 1'b1;
						rsv_addr_q <= ea_q;
					end
					if (it_q.mode_flags[FlUpdate]) gpr_q[it_q.reg_a] <= ea_q;
				end else begin
					res.data_value <= dv_q;
					if (rt == REQ_STORE) res.store_performed <= doit_q;
					else if (rt == REQ_STMW) res.store_performed <= 1'b1;
					else if (rt == REQ_STSW) res.store_performed <= (n_c != 8'd0);
					else res.store_performed <= 1'b0;
					if (rt == REQ_STORE && doit_q && it_q.mode_flags[FlUpdate])
						gpr_q[it_q.reg_a] <= ea_q;
				end
			end
		end
	end

	a_rsv_addr: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsv_valid_q) |-> rsv_addr_q == $past(ea_q)) else $error("reserve addr");
	a_cnt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> cnt_q == $past(cnt_q) - 8'd1) else $error("count");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> res_valid) else $error("no result");
endmodule
`default_nettype wire

[hw/rtl/load_store_unit_top.sv]
// Top level of the load/store unit: controller plus datapath.
// Depends on lsu_pkg, lsu_ctrl, lsu_dp.
//
// Usage: raise start with a request on req while busy is low; the item is
// taken at that edge and busy rises on the next cycle. The result appears on
// rsp, marked by done high for a single cycle; the receiver cannot stall it.
// Register requests pass through the address, finish and done states.
// Memory requests also walk the byte state, one step per byte moved: 1, 2
// or 4 for single loads/stores, 4*(32-reg_d) for multiples, the byte count
// for strings (up to 127). A memory request that moves nothing (failed
// conditional store, zero-count indexed string) still enters the byte state.
// The byte walker moves one byte per cycle through the single memory port,
// which sets the rate; busy is low in the cycle done is high, so the next item can be taken then.
// Reset clears the register file and the reservation; the memory holds
// whatever was written and is not cleared.
`default_nettype none
module load_store_unit_top #(
	parameter int MEM_BYTES = lsu_pkg::MemBytesDefault
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire lsu_pkg::lsu_in_t req,
	output lsu_pkg::lsu_out_t     rsp,
	output logic                  done
);
	import lsu_pkg::*;

	lsu_cmd_t cmd;
	lsu_sts_t sts;
	logic busy_c;

	lsu_ctrl u_ctrl (.clk, .arst_n, .start, .busy(busy_c), .cmd, .sts);
	lsu_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (.clk, .arst_n, .in_item(req), .cmd, .sts,
		.res(rsp), .res_valid(done));

	assign busy = busy_c;
endmodule
`default_nettype wire
